// ===== src/ebs_pkg.sv =====
// ----------------------------------------------------------------------------
// ebs_pkg
// Shared widths, codes and bundle types for the EEPROM burst splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ebs_pkg;

    // Field widths of the request and result channels
    localparam int ADDR_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int DEV_W    = 7;
    localparam int WORD_W   = 8;
    localparam int LEN_W    = 9;
    localparam int OFF_W    = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_READY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR    = 1'b1;
    localparam logic [DEV_W-1:0]     BASE_ADDR_RESET  = 7'd80;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_XFER      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    // Chunk limit per request
    localparam int MAX_RESULTS = 64;
    localparam int CHUNK_CNT_W = $clog2(MAX_RESULTS);
    localparam logic [CHUNK_CNT_W-1:0] CHUNK_CNT_LAST = CHUNK_CNT_W'(MAX_RESULTS - 1);

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                   is_write;
        logic [WORD_W-1:0]      inblock;
        logic [WORD_W-1:0]      page_off;
        logic [COUNT_W-1:0]     left;
        logic [CHUNK_CNT_W-1:0] count;
    } chunk_in_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              wrap;
        logic [WORD_W-1:0] inblock_next;
    } chunk_out_t;

endpackage

`default_nettype wire

// ===== src/ebs_req_if.sv =====
// ----------------------------------------------------------------------------
// ebs_req_if
// Request channel: opcode, start address and byte count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebs_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ebs_pkg::ADDR_W-1:0]  start_address;
    logic [ebs_pkg::COUNT_W-1:0] byte_count;

    modport source (output valid, output opcode, output start_address,
                    output byte_count, input ready);
    modport sink   (input valid, input opcode, input start_address,
                    input byte_count, output ready);
endinterface

`default_nettype wire

// ===== src/ebs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ebs_rsp_if
// Result channel: each result is one bus transfer or an error, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ebs_pkg::STATUS_W-1:0] status;
    logic [ebs_pkg::DEV_W-1:0]    device_address;
    logic [ebs_pkg::WORD_W-1:0]   word_address;
    logic [ebs_pkg::LEN_W-1:0]    chunk_length;
    logic [ebs_pkg::OFF_W-1:0]    buffer_offset;
    logic                        last_chunk;

    modport source (output valid, output status, output device_address,
                    output word_address, output chunk_length,
                    output buffer_offset, output last_chunk, input ready);
    modport sink   (input valid, input status, input device_address,
                    input word_address, input chunk_length,
                    input buffer_offset, input last_chunk, output ready);
endinterface

`default_nettype wire

// ===== src/ebs_divider.sv =====
// ----------------------------------------------------------------------------
// ebs_divider
// Shared compare-and-subtract unit: takes the divisor off the dividend once
// per cycle while it fits; splits an address into block number and offset,
// or an offset into page position.
// ----------------------------------------------------------------------------
`default_nettype none

module ebs_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ebs_pkg::div_req_t req,
    output ebs_pkg::div_rsp_t      rsp
);
    import ebs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] rem_reg;
    logic [LEN_W-1:0]  dsr_reg;
    logic [ADDR_W-1:0] quot_reg;

    logic [ADDR_W-1:0] dsr_ext;
    logic              ge;

    // Check whether one more divisor fits in what is left
    assign dsr_ext = ADDR_W'(dsr_reg);
    assign ge      = rem_reg >= dsr_ext;

    // Load operands on start, then subtract once per cycle until it no longer fits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && !ge;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    rem_reg  <= rem_reg - dsr_ext;
                    quot_reg <= quot_reg + ADDR_W'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg[WORD_W-1:0];

endmodule

`default_nettype wire

// ===== src/ebs_chunk.sv =====
// ----------------------------------------------------------------------------
// ebs_chunk
// Length of the next transfer: distance to the block end, to the write page
// end for writes, clamped to the bytes left; flags the final transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ebs_chunk #(
    parameter int BLOCK_BYTES      = 256,
    parameter int WRITE_PAGE_BYTES = 16
) (
    input  wire ebs_pkg::chunk_in_t cin,
    output ebs_pkg::chunk_out_t     cout
);
    import ebs_pkg::*;

    localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] PAGE_LEN  = LEN_W'(WRITE_PAGE_BYTES);

    logic [LEN_W-1:0] to_block;
    logic [LEN_W-1:0] to_page;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] sum;

    always_comb
    begin
        to_block = BLOCK_LEN - {1'b0, cin.inblock};
        to_page  = PAGE_LEN - {1'b0, cin.page_off};
        limit    = (cin.is_write && (to_page < to_block)) ? to_page : to_block;
        // Clamp to what is left of the request
        len      = ({{(COUNT_W-LEN_W){1'b0}}, limit} > cin.left) ? cin.left[LEN_W-1:0]
                                                                  : limit;
        sum      = {1'b0, cin.inblock} + len;

        cout.len          = len;
        cout.last         = ({{(COUNT_W-LEN_W){1'b0}}, len} == cin.left)
                            || (cin.count == CHUNK_CNT_LAST);
        cout.wrap         = (sum == BLOCK_LEN);
        cout.inblock_next = cout.wrap ? '0 : sum[WORD_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/eeprom_burst_splitter.sv =====
// ----------------------------------------------------------------------------
// eeprom_burst_splitter
// Splits EEPROM read/write requests into bus transfers at block and write
// page boundaries, with ready and range checks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     contents
//  req       in   valid/ready   opcode, start_address, byte_count
//  rsp       out  valid/ready   status, device_address, word_address,
//                               chunk_length, buffer_offset, last_chunk
//  cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
//  A request is taken on its handshake; errors and zero counts finish there.
//  A read divides start by BLOCK_BYTES by repeated subtraction in the shared
//  unit, latches block and offset, then emits one chunk per cycle while the
//  output register is free; the next request is taken after the last chunk.
//  A write also divides the offset by WRITE_PAGE_BYTES for its page position.
//  A stalled result holds in the output register; chunking waits for it.
//  Reset clears control state and sets the base device address to 80.
// ----------------------------------------------------------------------------
`default_nettype none

module eeprom_burst_splitter #(
    parameter int MEMORY_BYTES     = 1024,
    parameter int BLOCK_BYTES      = 256,
    parameter int WRITE_PAGE_BYTES = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ebs_req_if.sink                         req,
    ebs_rsp_if.source                       rsp,
    input  wire logic                       cfg_we,
    input  wire logic [ebs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ebs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ebs_pkg::*;

    localparam int SUM_W = ADDR_W + 2;
    localparam int MEM_W = $clog2(MEMORY_BYTES + 1);
    localparam int CMP_W = (MEM_W > SUM_W) ? MEM_W : SUM_W;
    localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(MEMORY_BYTES);
    localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] PAGE_LEN  = LEN_W'(WRITE_PAGE_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_BLK,
        ST_DIV_PG,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic                   dev_ready_reg;
    logic [DEV_W-1:0]       base_reg;
    logic                   is_write_reg;
    logic [COUNT_W-1:0]     left_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [DEV_W-1:0]       blk_reg;
    logic [WORD_W-1:0]      inblk_reg;
    logic [WORD_W-1:0]      pgoff_reg;
    logic [CHUNK_CNT_W-1:0] n_reg;

    logic                   rsp_vld_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [DEV_W-1:0]       dev_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [OFF_W-1:0]       boff_reg;
    logic                   last_reg;

    logic                   slot_free;
    logic                   accept;
    logic                   go;
    logic                   rsp_load;
    logic [CMP_W-1:0]       end_addr;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    chunk_in_t              cin;
    chunk_out_t             cout;

    assign slot_free = !rsp_vld_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign end_addr  = CMP_W'(req.start_address) + CMP_W'(req.byte_count);
    // Request that passes every check and starts splitting
    assign go        = accept && (req.byte_count != '0) && dev_ready_reg
                       && (end_addr <= MEM_LIMIT);
    // Output register takes an error result or the next chunk
    assign rsp_load  = (accept && (req.byte_count != '0) && !go)
                       || ((state_reg == ST_EMIT) && slot_free);

    // Drive the shared divider: block split first, page position after for writes
    always_comb
    begin
        div_req.start    = go || ((state_reg == ST_DIV_BLK) && div_rsp.done && is_write_reg);
        div_req.dividend = (state_reg == ST_IDLE) ? req.start_address
                                                  : ADDR_W'(div_rsp.remainder);
        div_req.divisor  = (state_reg == ST_IDLE) ? BLOCK_LEN : PAGE_LEN;
    end

    ebs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cin.is_write = is_write_reg;
        cin.inblock  = inblk_reg;
        cin.page_off = pgoff_reg;
        cin.left     = left_reg;
        cin.count    = n_reg;
    end

    ebs_chunk #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .WRITE_PAGE_BYTES (WRITE_PAGE_BYTES)
    ) u_chunk (
        .cin  (cin),
        .cout (cout)
    );

    // Sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dev_ready_reg <= 1'b0;
            base_reg      <= BASE_ADDR_RESET;
            rsp_vld_reg   <= 1'b0;
            is_write_reg  <= 1'b0;
            left_reg      <= '0;
            off_reg       <= '0;
            blk_reg       <= '0;
            inblk_reg     <= '0;
            pgoff_reg     <= '0;
            n_reg         <= '0;
            status_reg    <= STATUS_XFER;
            dev_reg       <= '0;
            word_reg      <= '0;
            len_reg       <= '0;
            boff_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEVICE_READY: dev_ready_reg <= cfg_data[0];
                    CFG_BASE_ADDR:    base_reg      <= cfg_data;
                    default:          ;
                endcase
            end

            // Load a new result, or drop the current one once taken
            if (rsp_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req.byte_count != '0) && !go)
                    begin
                        status_reg  <= dev_ready_reg ? STATUS_RANGE : STATUS_NOT_READY;
                        dev_reg     <= '0;
                        word_reg    <= '0;
                        len_reg     <= '0;
                        boff_reg    <= '0;
                        last_reg    <= 1'b1;
                    end
                    if (go)
                    begin
                        is_write_reg <= req.opcode;
                        left_reg     <= req.byte_count;
                        off_reg      <= '0;
                        n_reg        <= '0;
                        state_reg    <= ST_DIV_BLK;
                    end
                end
                ST_DIV_BLK:
                begin
                    if (div_rsp.done)
                    begin
                        blk_reg   <= div_rsp.quotient[DEV_W-1:0];
                        inblk_reg <= div_rsp.remainder;
                        pgoff_reg <= '0;
                        state_reg <= is_write_reg ? ST_DIV_PG : ST_EMIT;
                    end
                end
                ST_DIV_PG:
                begin
                    if (div_rsp.done)
                    begin
                        pgoff_reg <= div_rsp.remainder;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // Emit one chunk whenever the output register frees up
                    if (slot_free)
                    begin
                        status_reg  <= STATUS_XFER;
                        dev_reg     <= base_reg + blk_reg;
                        word_reg    <= inblk_reg;
                        len_reg     <= cout.len;
                        boff_reg    <= off_reg;
                        last_reg    <= cout.last;

                        left_reg    <= left_reg - COUNT_W'(cout.len);
                        off_reg     <= off_reg + OFF_W'(cout.len);
                        n_reg       <= n_reg + 1'b1;
                        inblk_reg   <= cout.inblock_next;
                        blk_reg     <= blk_reg + DEV_W'(cout.wrap);
                        pgoff_reg   <= '0;
                        if (cout.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.status         = status_reg;
    assign rsp.device_address = dev_reg;
    assign rsp.word_address   = word_reg;
    assign rsp.chunk_length   = len_reg;
    assign rsp.buffer_offset  = boff_reg;
    assign rsp.last_chunk     = last_reg;

    // A chunk is never empty and never takes more bytes than are left
    a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ({2'b0, cout.len} <= left_reg) && (cout.len != '0))
        else $error("chunk length exceeds remaining bytes or is zero");

    // A transfer never crosses the end of its block
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && (status_reg == STATUS_XFER))
        |-> ({1'b0, word_reg} + len_reg <= BLOCK_LEN))
        else $error("transfer crosses a block boundary");

    // The divider reports only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == ST_DIV_BLK) || (state_reg == ST_DIV_PG)))
        else $error("divider result outside a divide phase");

    // Error results always close their request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && (status_reg != STATUS_XFER)) |-> last_reg && (len_reg == '0))
        else $error("error result not marked final");

endmodule

`default_nettype wire
